### design/npc_pkg.sv
// npc_pkg: shared types, constants and helpers for the narrow-phase collision block
// used by npc_front, npc_queue, npc_back and the top level; no dependencies
package npc_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int NormW  = 16;
  localparam logic signed [NormW-1:0] NormOne = 16'sd16384;

  // shape kinds
  localparam logic KindBox    = 1'b0;
  localparam logic KindSphere = 1'b1;

  // job passed from front to back
  typedef struct packed {
    logic                          is_round;
    logic                          bb_hit;
    logic signed [NormW-1:0]       bb_nx;
    logic signed [NormW-1:0]       bb_ny;
    logic signed [NormW-1:0]       bb_nz;
    logic [CoordW-1:0]             bb_depth;
    logic signed [2:0][DiffW-1:0]  d;
    logic signed [DiffW-1:0]       rad;
  } job_t;

  // saturate a signed depth to unsigned 32 bits
  function automatic logic [CoordW-1:0] sat_depth(input logic signed [34:0] v);
    logic [CoordW-1:0] r;
    if (v < 0) r = '0;
    else if (v > 35'sh0_FFFF_FFFF) r = '1;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  // magnitude of a signed difference
  function automatic logic [DiffW-1:0] mag(input logic signed [DiffW-1:0] v);
    logic [DiffW-1:0] r;
    r = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
    return r;
  endfunction

endpackage

### design/narrow_phase_collision_test.sv
// narrow_phase_collision_test: top level of the box and sphere narrow-phase test
// depends on npc_pkg, npc_front, npc_queue, npc_back
//
// usage: drive an item with start high while busy is low. an item with
// is_second low stores shape A and gives no result; one with is_second high
// tests shape B against A and later gives one result, hit, normal_* and
// depth, marked by done for exactly one cycle. the receiver cannot stall;
// results leave in the order the pairs were taken.
// steps: a box pair is answered when loaded from the queue; a pair with a
// sphere is loaded and squared on one shared multiplier and ends there on a
// miss; with coincident centres it adds a bit-pair square root, and otherwise
// that root and then three parallel restoring dividers for the normal. the
// back end works on one job at a time, its pace set by the square root and
// divider loop, while new items are taken into the queue until it is full.
// busy is high while the job queue is full. reset clears the queue, the back
// end and the stored shape kind.
module narrow_phase_collision_test #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic                is_second,
  input  logic signed [31:0]  low_x,
  input  logic signed [31:0]  low_y,
  input  logic signed [31:0]  low_z,
  input  logic signed [31:0]  high_x,
  input  logic signed [31:0]  high_y,
  input  logic signed [31:0]  high_z,
  output logic                done,
  output logic                hit,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic [31:0]         depth
);
  import npc_pkg::*;

  logic take, push, pop, empty, full;
  job_t job, rdata;

  assign busy = full;
  assign take = start && !busy;

  npc_front u_front (
    .clk, .rst, .take, .mode, .is_second,
    .low_x, .low_y, .low_z, .high_x, .high_y, .high_z,
    .push, .job
  );

  npc_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .wdata(job), .pop, .rdata, .empty, .full
  );

  npc_back u_back (
    .clk, .rst, .empty, .rdata, .pop,
    .done, .hit, .normal_x, .normal_y, .normal_z, .depth
  );

endmodule

### design/npc_front.sv
// npc_front: takes items, keeps shape A, classifies pairs and builds jobs
// depends on npc_pkg
module npc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          mode,
  input  logic                          is_second,
  input  logic signed [31:0]            low_x,
  input  logic signed [31:0]            low_y,
  input  logic signed [31:0]            low_z,
  input  logic signed [31:0]            high_x,
  input  logic signed [31:0]            high_y,
  input  logic signed [31:0]            high_z,
  output logic                          push,
  output npc_pkg::job_t                 job
);
  import npc_pkg::*;

  logic                       first_kind;
  logic signed [31:0]         first_low [3];
  logic signed [31:0]         first_high [3];
  logic signed [31:0]         lo_in [3];
  logic signed [31:0]         hi_in [3];

  assign lo_in[0] = low_x;
  assign lo_in[1] = low_y;
  assign lo_in[2] = low_z;
  assign hi_in[0] = high_x;
  assign hi_in[1] = high_y;
  assign hi_in[2] = high_z;

  // shape a storage
  always_ff @(posedge clk) begin
    if (rst) begin
      first_kind <= KindBox;
    end else if (take && !is_second) begin
      first_kind <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_second) begin
      first_low  <= lo_in;
      first_high <= hi_in;
    end
  end

  assign push = take && is_second;

  // box-box overlap and per-pair difference vectors
  logic signed [DiffW-1:0]      ov [3];
  logic signed [2:0][DiffW-1:0] diff;
  logic signed [DiffW-1:0]      rad;
  logic                         bb_hit;
  logic [1:0]                   ax;
  logic signed [DiffW-1:0]      ov_sel;
  logic                         neg_sel;
  logic signed [NormW-1:0]      s;
  logic signed [31:0]           bx_lo [3];
  logic signed [31:0]           bx_hi [3];
  logic signed [31:0]           ctr [3];
  logic signed [31:0]           clmp;

  always_comb begin
    bb_hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ov[i] = DiffW'(((first_high[i] < hi_in[i]) ? first_high[i] : hi_in[i]))
            - DiffW'(((first_low[i] > lo_in[i]) ? first_low[i] : lo_in[i]));
      if (ov[i] <= 0) bb_hit = 1'b0;
    end
    if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 2'd0;
    else if (ov[1] < ov[2])            ax = 2'd1;
    else                               ax = 2'd2;
    ov_sel  = ov[ax];
    neg_sel = (DiffW'(first_low[ax]) + DiffW'(first_high[ax]))
            < (DiffW'(lo_in[ax]) + DiffW'(hi_in[ax]));
    s = neg_sel ? -NormOne : NormOne;

    // pick box and sphere roles
    for (int i = 0; i < 3; i++) begin
      if (first_kind == KindBox) begin
        bx_lo[i] = first_low[i];
        bx_hi[i] = first_high[i];
        ctr[i]   = lo_in[i];
      end else begin
        bx_lo[i] = lo_in[i];
        bx_hi[i] = hi_in[i];
        ctr[i]   = first_low[i];
      end
    end
    rad = (first_kind == KindBox) ? DiffW'(high_x) : DiffW'(first_high[0]);
    for (int i = 0; i < 3; i++) begin
      clmp = (ctr[i] < bx_hi[i]) ? ctr[i] : bx_hi[i];
      clmp = (bx_lo[i] > clmp) ? bx_lo[i] : clmp;
      diff[i] = DiffW'(ctr[i]) - DiffW'(clmp);
    end
    if (first_kind == KindSphere && mode == KindSphere) begin
      for (int i = 0; i < 3; i++) diff[i] = DiffW'(lo_in[i]) - DiffW'(first_low[i]);
      rad = DiffW'(first_high[0]) + DiffW'(high_x);
    end
  end

  // job assembly
  always_comb begin
    job          = '0;
    job.is_round = !(first_kind == KindBox && mode == KindBox);
    job.bb_hit   = bb_hit;
    if (bb_hit) begin
      job.bb_nx    = (ax == 2'd0) ? s : '0;
      job.bb_ny    = (ax == 2'd1) ? s : '0;
      job.bb_nz    = (ax == 2'd2) ? s : '0;
      job.bb_depth = sat_depth(35'(ov_sel));
    end
    job.d   = diff;
    job.rad = rad;
  end

endmodule

### design/npc_queue.sv
// npc_queue: short job queue between front and back
// depends on npc_pkg
module npc_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  npc_pkg::job_t   wdata,
  input  logic            pop,
  output npc_pkg::job_t   rdata,
  output logic            empty,
  output logic            full
);
  import npc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CntW'(Depth));

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
    if (pop)  rdata <= mem[rd_ptr];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue pop while empty");

endmodule

### design/npc_back.sv
// npc_back: runs jobs: squares, hit test, square root, normal division, result
// depends on npc_pkg
module npc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  npc_pkg::job_t        rdata,
  output logic                 pop,
  output logic                 done,
  output logic                 hit,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic signed [15:0]   normal_z,
  output logic [31:0]          depth
);
  import npc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_SQUARE = 5'b00100,
    S_SQRT   = 5'b01000,
    S_DIV    = 5'b10000
  } state_t;

  state_t state;
  logic [5:0]                   cnt;
  logic [2:0][DiffW-1:0]        m;
  logic [2:0]                   neg;
  logic signed [DiffW-1:0]      rad;
  logic [DiffW-1:0]             rmag;
  logic [66:0]                  dsq;
  logic [67:0]                  sq_in;
  logic [35:0]                  rem;
  logic [33:0]                  root;
  logic [2:0][47:0]             num;
  logic [47:0]                  dsh;
  logic [2:0][14:0]             q;

  // shared multiplier operand
  logic [DiffW-1:0] mop;
  logic [65:0]      prod;
  always_comb begin
    case (cnt[1:0])
      2'd0:    mop = m[0];
      2'd1:    mop = m[1];
      2'd2:    mop = m[2];
      default: mop = rmag;
    endcase
    prod = 66'(mop) * 66'(mop);
  end

  // square root step
  logic [37:0] rem2;
  logic [37:0] trial;
  always_comb begin
    rem2  = {rem, sq_in[67:66]};
    trial = {2'b00, root, 2'b01};
  end

  logic signed [34:0] dep;
  assign dep = 35'(rad) - $signed({1'b0, root});

  assign pop = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (!empty) state <= S_LOAD;
        S_LOAD: begin
          if (!rdata.is_round) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: if (cnt == 6'd3) begin
          if (dsq >= 67'(prod)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: if (cnt == 6'd33) begin
          if (root[32:0] == '0 && rem2 < trial) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: if (cnt == 6'd14) begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        cnt <= '0;
        dsq <= '0;
        rad <= rdata.rad;
        rmag <= mag(rdata.rad);
        for (int i = 0; i < 3; i++) begin
          m[i]   <= mag(rdata.d[i]);
          neg[i] <= rdata.d[i][DiffW-1];
        end
        hit      <= rdata.bb_hit;
        normal_x <= rdata.bb_nx;
        normal_y <= rdata.bb_ny;
        normal_z <= rdata.bb_nz;
        depth    <= rdata.bb_depth;
      end
      S_SQUARE: begin
        if (cnt == 6'd3) begin
          cnt   <= '0;
          sq_in <= {1'b0, dsq};
          rem   <= '0;
          root  <= '0;
          hit      <= 1'b0;
          normal_x <= '0;
          normal_y <= '0;
          normal_z <= '0;
          depth    <= '0;
        end else begin
          dsq <= dsq + 67'(prod);
          cnt <= cnt + 6'd1;
        end
      end
      S_SQRT: begin
        sq_in <= {sq_in[65:0], 2'b00};
        if (rem2 >= trial) begin
          rem  <= 36'(rem2 - trial);
          root <= {root[32:0], 1'b1};
        end else begin
          rem  <= rem2[35:0];
          root <= {root[32:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd33) begin
          cnt <= '0;
          hit <= 1'b1;
          if (root[32:0] == '0 && rem2 < trial) begin
            normal_y <= NormOne;
            depth    <= sat_depth(35'(rad));
          end
        end
      end
      S_DIV: begin
        if (cnt == 6'd0 && dsh == '0) begin
          dsh <= '0;
        end
        for (int i = 0; i < 3; i++) begin
          if (num[i] >= dsh) begin
            num[i] <= num[i] - dsh;
            q[i]   <= {q[i][13:0], 1'b1};
          end else begin
            q[i]   <= {q[i][13:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd14) begin
          normal_x <= neg[0] ? -$signed({1'b0, q[0][13:0], num[0] >= dsh})
                             : $signed({1'b0, q[0][13:0], num[0] >= dsh});
          normal_y <= neg[1] ? -$signed({1'b0, q[1][13:0], num[1] >= dsh})
                             : $signed({1'b0, q[1][13:0], num[1] >= dsh});
          normal_z <= neg[2] ? -$signed({1'b0, q[2][13:0], num[2] >= dsh})
                             : $signed({1'b0, q[2][13:0], num[2] >= dsh});
          depth    <= sat_depth(dep);
        end
      end
      default: ;
    endcase
    // division setup once the root is final
    if (state == S_SQRT && cnt == 6'd33) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= {1'b0, m[i], 14'b0} + 48'({root[32:0], rem2 >= trial} >> 1);
        q[i]   <= '0;
      end
      dsh <= {root[32:0], rem2 >= trial, 14'b0};
    end
  end

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results in a row");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0 && depth == 0))
    else $error("miss with nonzero fields");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_LOAD)) else $error("pop without load");

endmodule
